@@ hw/rtl/ssm_pkg.sv @@
// shared types and constants for the subsystem sleep stall monitor
package ssm_pkg;

    localparam int LIMIT_CLIENTS   = 3;
    localparam int LIMIT_BITS      = 16;
    localparam int TIME_BITS       = 64;
    localparam int CFG_INDEX_BITS  = 3;

    localparam logic [LIMIT_BITS-1:0] DEF_FATAL_LIMIT = 16'd5;
    localparam logic [LIMIT_BITS-1:0] DEF_ERROR_LIMIT = DEF_FATAL_LIMIT * 16'd2;

    localparam logic [1:0] OP_ENTRY = 2'd0;
    localparam logic [1:0] OP_EXIT  = 2'd1;
    localparam logic [1:0] OP_CHECK = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_ERR_LIMIT0 = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ERR_LIMIT2 = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FAT_LIMIT0 = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_FAT_LIMIT2 = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_REC_MASK   = 3'd6;

    typedef struct packed {
        logic [1:0]           operation;
        logic [1:0]           client;
        logic [TIME_BITS-1:0] duration;
        logic                 voice_active;
    } in_t;

    typedef struct packed {
        logic [1:0]            result_client;
        logic                  restart;
        logic                  force_recovery;
        logic [LIMIT_BITS-1:0] errors;
        logic [LIMIT_BITS-1:0] fatals;
        logic [LIMIT_BITS-1:0] recoveries;
        logic                  last;
    } out_t;

    typedef struct packed {
        logic [LIMIT_CLIENTS-1:0][LIMIT_BITS-1:0] err_limit;
        logic [LIMIT_CLIENTS-1:0][LIMIT_BITS-1:0] fat_limit;
        logic [LIMIT_CLIENTS-1:0]                 rec_mask;
    } cfg_t;

    typedef struct packed {
        logic [TIME_BITS-1:0] exit_time;
        logic [TIME_BITS-1:0] entry_time;
    } time_pair_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_EXEC
    } state_t;

endpackage

@@ hw/rtl/ssm_cfg.sv @@
// configuration registers: per-client limits and recovery enable mask
module ssm_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ssm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [ssm_pkg::LIMIT_BITS-1:0]      cfg_wdata,
    output ssm_pkg::cfg_t                       cfg
);

    ssm_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ssm_pkg::LIMIT_CLIENTS; i++)
            begin
                cfg_reg.err_limit[i] <= ssm_pkg::DEF_ERROR_LIMIT;
                cfg_reg.fat_limit[i] <= ssm_pkg::DEF_FATAL_LIMIT;
            end
            cfg_reg.rec_mask <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index) inside
                [ssm_pkg::REG_ERR_LIMIT0:ssm_pkg::REG_ERR_LIMIT2]:
                    cfg_reg.err_limit[2'(cfg_index - ssm_pkg::REG_ERR_LIMIT0)] <= cfg_wdata;
                [ssm_pkg::REG_FAT_LIMIT0:ssm_pkg::REG_FAT_LIMIT2]:
                    cfg_reg.fat_limit[2'(cfg_index - ssm_pkg::REG_FAT_LIMIT0)] <= cfg_wdata;
                ssm_pkg::REG_REC_MASK:
                    cfg_reg.rec_mask <= cfg_wdata[ssm_pkg::LIMIT_CLIENTS-1:0];
                default:
                    cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ hw/rtl/subsystem_sleep_stall_monitor.sv @@
// subsystem sleep stall monitor top level: sequencer, state memories, result register
//
// input words carry an operation: sleep entry mark, sleep exit mark or monitor check.
// entry and exit marks update the client's stored times and stall counts and give
// no result; a check walks up to three clients and gives one result word per
// client, the final one flagged by last.
// the per-client state sits in two single-port memories (times and counts) with a
// registered read; each mark, and each client step of a check, is a read, a modify and a write-back of one entry.
// a mark passes through the read and execute steps and then returns to idle; a check
// repeats the read and execute steps for each client that it walks. in_ready is high
// only while the sequencer is idle.
// results go through an output register; while it is full and out_ready is low,
// the walk holds in its execute step and nothing is lost.
// reset returns the limits to their defaults and marks every memory entry as
// unwritten, so it reads as zero; no clearing pass is needed.
// the configuration port takes a write on any cycle with cfg_we high.
module subsystem_sleep_stall_monitor #(
    parameter int CLIENTS    = 3,
    parameter int COUNT_BITS = 16
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ssm_pkg::in_t                        in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ssm_pkg::out_t                       out_data,
    input  logic                                cfg_we,
    input  logic [ssm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [ssm_pkg::LIMIT_BITS-1:0]      cfg_wdata
);

    localparam int AW   = (CLIENTS > 1) ? $clog2(CLIENTS) : 1;
    localparam int WALK = (CLIENTS < ssm_pkg::LIMIT_CLIENTS) ? CLIENTS : ssm_pkg::LIMIT_CLIENTS;
    localparam int CW   = 3 * COUNT_BITS;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [AW-1:0] LAST_IDX = AW'(WALK - 1);

    ssm_pkg::cfg_t       cfg;
    ssm_pkg::state_t     state_reg, state_next;
    ssm_pkg::in_t        item_reg;
    logic [AW-1:0]       idx_reg, idx_next;
    logic [CLIENTS-1:0]  written_reg;

    ssm_pkg::time_pair_t tmem [CLIENTS];
    logic [CW-1:0]       cmem [CLIENTS];
    ssm_pkg::time_pair_t trd_reg;
    logic [CW-1:0]       crd_reg;
    logic                rd_written_reg;

    logic                out_valid_reg, out_valid_next;
    ssm_pkg::out_t       out_data_reg, out_data_next;

    logic                accept;
    logic                mark_ok;
    logic                is_check;
    logic                rd_en;
    logic                exec_go;
    logic [1:0]          lidx;

    ssm_pkg::time_pair_t t_cur, t_new;
    logic [COUNT_BITS-1:0] err_cur, fat_cur, rec_cur;
    logic [COUNT_BITS-1:0] err_new, fat_new, rec_new;
    logic [31:0]         err_lim, fat_lim;
    logic                rs, fr;

    ssm_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    assign accept   = in_valid && in_ready;
    assign mark_ok  = (in_data.operation == ssm_pkg::OP_ENTRY ||
                       in_data.operation == ssm_pkg::OP_EXIT) &&
                      (32'(in_data.client) < CLIENTS);
    assign is_check = (item_reg.operation == ssm_pkg::OP_CHECK);
    assign lidx     = 2'(idx_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ssm_pkg::S_IDLE:
            begin
                if (accept && in_data.operation == ssm_pkg::OP_CHECK)
                begin
                    state_next = ssm_pkg::S_READ;
                    idx_next   = '0;
                end
                else if (accept && mark_ok)
                begin
                    state_next = ssm_pkg::S_READ;
                    idx_next   = AW'(in_data.client);
                end
            end
            ssm_pkg::S_READ:
                state_next = ssm_pkg::S_EXEC;
            ssm_pkg::S_EXEC:
            begin
                if (exec_go)
                begin
                    if (is_check && idx_reg != LAST_IDX)
                    begin
                        state_next = ssm_pkg::S_READ;
                        idx_next   = idx_reg + AW'(1);
                    end
                    else
                    begin
                        state_next = ssm_pkg::S_IDLE;
                    end
                end
            end
            default:
                state_next = ssm_pkg::S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        in_ready = 1'b0;
        rd_en    = 1'b0;
        exec_go  = 1'b0;
        unique case (state_reg)
            ssm_pkg::S_IDLE: in_ready = 1'b1;
            ssm_pkg::S_READ: rd_en    = 1'b1;
            ssm_pkg::S_EXEC: exec_go  = !is_check || !out_valid_reg || out_ready;
            default:         in_ready = 1'b0;
        endcase
    end

    // read-modify-write of one client entry
    always_comb
    begin
        t_cur   = rd_written_reg ? trd_reg : '0;
        err_cur = rd_written_reg ? crd_reg[COUNT_BITS-1:0] : '0;
        fat_cur = rd_written_reg ? crd_reg[2*COUNT_BITS-1:COUNT_BITS] : '0;
        rec_cur = rd_written_reg ? crd_reg[CW-1:2*COUNT_BITS] : '0;
        err_lim = 32'(cfg.err_limit[lidx]);
        fat_lim = 32'(cfg.fat_limit[lidx]);
        t_new   = t_cur;
        err_new = err_cur;
        fat_new = fat_cur;
        rec_new = rec_cur;
        rs      = 1'b0;
        fr      = 1'b0;
        case (item_reg.operation)
            ssm_pkg::OP_ENTRY:
                t_new.entry_time = item_reg.duration;
            ssm_pkg::OP_EXIT:
            begin
                if (!(idx_reg == '0 && item_reg.voice_active))
                begin
                    if (item_reg.duration == t_cur.entry_time)
                    begin
                        err_new = (err_cur == COUNT_MAX) ? err_cur : err_cur + 1'b1;
                        if (item_reg.duration == t_cur.exit_time)
                            fat_new = (fat_cur == COUNT_MAX) ? fat_cur : fat_cur + 1'b1;
                    end
                    else
                    begin
                        err_new = '0;
                        fat_new = '0;
                    end
                end
                t_new.exit_time = item_reg.duration;
            end
            ssm_pkg::OP_CHECK:
            begin
                rs = (32'(err_cur) > err_lim) || (32'(fat_cur) > fat_lim);
                fr = rs && cfg.rec_mask[lidx] && (32'(rec_cur) < err_lim);
                if (fr)
                    rec_new = (rec_cur == COUNT_MAX) ? rec_cur : rec_cur + 1'b1;
                if (rs)
                begin
                    err_new = '0;
                    fat_new = '0;
                end
            end
            default:
                t_new = t_cur;
        endcase
    end

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (exec_go && is_check)
        begin
            out_valid_next               = 1'b1;
            out_data_next.result_client  = lidx;
            out_data_next.restart        = rs;
            out_data_next.force_recovery = fr;
            out_data_next.errors         = ssm_pkg::LIMIT_BITS'(err_new);
            out_data_next.fatals         = ssm_pkg::LIMIT_BITS'(fat_new);
            out_data_next.recoveries     = ssm_pkg::LIMIT_BITS'(rec_new);
            out_data_next.last           = (idx_reg == LAST_IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ssm_pkg::S_IDLE;
            idx_reg       <= '0;
            written_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            if (exec_go)
                written_reg[idx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= in_data;
        out_data_reg <= out_data_next;
        if (rd_en)
            rd_written_reg <= written_reg[idx_reg];
    end

    // time memory
    always_ff @(posedge clk)
    begin
        if (exec_go)
            tmem[idx_reg] <= t_new;
        if (rd_en)
            trd_reg <= tmem[idx_reg];
    end

    // count memory
    always_ff @(posedge clk)
    begin
        if (exec_go)
            cmem[idx_reg] <= {rec_new, fat_new, err_new};
        if (rd_en)
            crd_reg <= cmem[idx_reg];
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

@@ tb/stall_check_pkg.sv @@
// scoreboard class predicting and checking the stall monitor's result words
package stall_check_pkg;

    class stall_scoreboard;
        logic [ssm_pkg::LIMIT_BITS-1:0]    err_limit      [ssm_pkg::LIMIT_CLIENTS];
        logic [ssm_pkg::LIMIT_BITS-1:0]    fat_limit      [ssm_pkg::LIMIT_CLIENTS];
        logic [ssm_pkg::LIMIT_CLIENTS-1:0] rec_mask;
        logic [ssm_pkg::TIME_BITS-1:0]     entry_time     [ssm_pkg::LIMIT_CLIENTS];
        logic [ssm_pkg::TIME_BITS-1:0]     exit_time      [ssm_pkg::LIMIT_CLIENTS];
        logic [ssm_pkg::LIMIT_BITS-1:0]    err_cnt        [ssm_pkg::LIMIT_CLIENTS];
        logic [ssm_pkg::LIMIT_BITS-1:0]    fat_cnt        [ssm_pkg::LIMIT_CLIENTS];
        logic [ssm_pkg::LIMIT_BITS-1:0]    recovery_count [ssm_pkg::LIMIT_CLIENTS];
        ssm_pkg::out_t                     due_reports    [$];
        int unsigned                       mismatches;

        function new();
            for (int i = 0; i < ssm_pkg::LIMIT_CLIENTS; i++)
            begin
                err_limit[i]      = ssm_pkg::DEF_ERROR_LIMIT;
                fat_limit[i]      = ssm_pkg::DEF_FATAL_LIMIT;
                entry_time[i]     = '0;
                exit_time[i]      = '0;
                err_cnt[i]        = '0;
                fat_cnt[i]        = '0;
                recovery_count[i] = '0;
            end
            rec_mask   = '0;
            mismatches = 0;
        endfunction

        function void write_reg(logic [ssm_pkg::CFG_INDEX_BITS-1:0] idx,
                                logic [ssm_pkg::LIMIT_BITS-1:0] value);
            if (idx >= ssm_pkg::REG_ERR_LIMIT0 && idx <= ssm_pkg::REG_ERR_LIMIT2)
                err_limit[idx - ssm_pkg::REG_ERR_LIMIT0] = value;
            else if (idx >= ssm_pkg::REG_FAT_LIMIT0 && idx <= ssm_pkg::REG_FAT_LIMIT2)
                fat_limit[idx - ssm_pkg::REG_FAT_LIMIT0] = value;
            else if (idx == ssm_pkg::REG_REC_MASK)
                rec_mask = value[ssm_pkg::LIMIT_CLIENTS-1:0];
        endfunction

        function logic [ssm_pkg::LIMIT_BITS-1:0] bump(logic [ssm_pkg::LIMIT_BITS-1:0] v);
            return (v == '1) ? v : v + 1'b1;
        endfunction

        function void note_word(ssm_pkg::in_t w);
            int            c;
            ssm_pkg::out_t r;
            c = w.client;
            case (w.operation)
                ssm_pkg::OP_ENTRY:
                begin
                    if (c < ssm_pkg::LIMIT_CLIENTS)
                        entry_time[c] = w.duration;
                end
                ssm_pkg::OP_EXIT:
                begin
                    if (c < ssm_pkg::LIMIT_CLIENTS)
                    begin
                        if (!(c == 0 && w.voice_active))
                        begin
                            if (w.duration == entry_time[c])
                            begin
                                err_cnt[c] = bump(err_cnt[c]);
                                if (w.duration == exit_time[c])
                                    fat_cnt[c] = bump(fat_cnt[c]);
                            end
                            else
                            begin
                                err_cnt[c] = '0;
                                fat_cnt[c] = '0;
                            end
                        end
                        exit_time[c] = w.duration;
                    end
                end
                ssm_pkg::OP_CHECK:
                begin
                    for (int i = 0; i < ssm_pkg::LIMIT_CLIENTS; i++)
                    begin
                        r = '0;
                        r.result_client = 2'(i);
                        r.restart = (err_cnt[i] > err_limit[i]) ||
                                    (fat_cnt[i] > fat_limit[i]);
                        if (r.restart)
                        begin
                            if (rec_mask[i] && recovery_count[i] < err_limit[i])
                            begin
                                r.force_recovery  = 1'b1;
                                recovery_count[i] = bump(recovery_count[i]);
                            end
                            err_cnt[i] = '0;
                            fat_cnt[i] = '0;
                        end
                        r.errors     = err_cnt[i];
                        r.fatals     = fat_cnt[i];
                        r.recoveries = recovery_count[i];
                        r.last       = (i == ssm_pkg::LIMIT_CLIENTS - 1);
                        due_reports.push_back(r);
                    end
                end
                default: ;
            endcase
        endfunction

        function string describe(ssm_pkg::out_t r);
            return {$sformatf("client %0d restart %0b recovery %0b ", r.result_client,
                              r.restart, r.force_recovery),
                    $sformatf("errors %0d fatals %0d recoveries %0d last %0b", r.errors,
                              r.fatals, r.recoveries, r.last)};
        endfunction

        function void compare_report(ssm_pkg::out_t got);
            ssm_pkg::out_t want;
            if (due_reports.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result word: %s", describe(got));
                return;
            end
            want = due_reports.pop_front();
            if (got.result_client !== want.result_client || got.restart !== want.restart ||
                got.force_recovery !== want.force_recovery || got.errors !== want.errors ||
                got.fatals !== want.fatals || got.recoveries !== want.recoveries ||
                got.last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: expected %s, got %s",
                             describe(want), describe(got));
            end
        endfunction
    endclass

endpackage

@@ tb/tb.sv @@
// top-level testbench for the subsystem sleep stall monitor
module tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0]                         OP_NONE       = 2'd3;
    localparam logic [ssm_pkg::CFG_INDEX_BITS-1:0] REG_NONE      = 3'd7;
    localparam int unsigned                        CYCLE_LIMIT   = 200_000;
    localparam int unsigned                        SETTLE_CYCLES = 12;
    localparam int unsigned                        PHASE_WORDS   = 70;
    localparam int unsigned                        STALL_EXITS   = 12;

    logic                               clk;
    logic                               rst_n;
    logic                               in_valid;
    logic                               in_ready;
    ssm_pkg::in_t                       in_data;
    logic                               out_valid;
    logic                               out_ready;
    ssm_pkg::out_t                      out_data;
    logic                               cfg_we;
    logic [ssm_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [ssm_pkg::LIMIT_BITS-1:0]     cfg_wdata;

    int unsigned                     send_idle_pct = 0;
    int unsigned                     stall_pct     = 0;
    int unsigned                     cycle_count   = 0;
    logic [ssm_pkg::TIME_BITS-1:0]   stall_time [ssm_pkg::LIMIT_CLIENTS];
    stall_check_pkg::stall_scoreboard sb;

    subsystem_sleep_stall_monitor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.compare_report(out_data);
            if (in_valid && in_ready)
                sb.note_word(in_data);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("subsystem_sleep_stall_monitor regression: fail");
            $finish;
        end
    end

    function automatic ssm_pkg::in_t pack_word(logic [1:0] op, logic [1:0] c,
                                               logic [ssm_pkg::TIME_BITS-1:0] d, logic v);
        ssm_pkg::in_t w;
        w.operation    = op;
        w.client       = c;
        w.duration     = d;
        w.voice_active = v;
        return w;
    endfunction

    function automatic logic [ssm_pkg::LIMIT_BITS-1:0] pick_limit(int unsigned kind);
        int unsigned r;
        r = $urandom_range(7);
        if (kind == 0)
            return '0;
        if (kind == 3)
            return '1;
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return ssm_pkg::LIMIT_BITS'($urandom_range(1, 6));
    endfunction

    task automatic send_word(input ssm_pkg::in_t w);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.due_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic load_reg(input logic [ssm_pkg::CFG_INDEX_BITS-1:0] idx,
                            input logic [ssm_pkg::LIMIT_BITS-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        sb.write_reg(idx, value);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic load_settings(input int unsigned kind);
        logic [ssm_pkg::LIMIT_BITS-1:0] mask_word;
        for (int i = 0; i < ssm_pkg::LIMIT_CLIENTS; i++)
        begin
            load_reg(ssm_pkg::CFG_INDEX_BITS'(ssm_pkg::REG_ERR_LIMIT0 + i), pick_limit(kind));
            load_reg(ssm_pkg::CFG_INDEX_BITS'(ssm_pkg::REG_FAT_LIMIT0 + i), pick_limit(kind));
        end
        // upper bits of the mask word are don't-care
        mask_word = ssm_pkg::LIMIT_BITS'($urandom);
        if (kind == 0)
            mask_word[ssm_pkg::LIMIT_CLIENTS-1:0] = '1;
        else if (kind == 3)
            mask_word[ssm_pkg::LIMIT_CLIENTS-1:0] = '0;
        load_reg(ssm_pkg::REG_REC_MASK, mask_word);
    endtask

    task automatic directed_words();
        send_word(pack_word(ssm_pkg::OP_ENTRY, 2'd0, '0, 1'b0));
        send_word(pack_word(ssm_pkg::OP_EXIT,  2'd0, '0, 1'b0));
        send_word(pack_word(ssm_pkg::OP_ENTRY, 2'd1, '1, 1'b1));
        send_word(pack_word(ssm_pkg::OP_EXIT,  2'd1, '1, 1'b1));
        send_word(pack_word(ssm_pkg::OP_EXIT,  2'd1, '1, 1'b0));
        // voice flag holds client 0 counts
        send_word(pack_word(ssm_pkg::OP_EXIT,  2'd0, '0, 1'b1));
        send_word(pack_word(ssm_pkg::OP_CHECK, 2'd0, '0, 1'b0));
        send_word(pack_word(ssm_pkg::OP_ENTRY, 2'd2, 64'h5555_5555_5555_5555, 1'b0));
        send_word(pack_word(ssm_pkg::OP_EXIT,  2'd2, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1));
        send_word(pack_word(ssm_pkg::OP_EXIT,  2'd0, 64'd1, 1'b0));
        // out-of-range client and unknown operation
        send_word(pack_word(ssm_pkg::OP_ENTRY, 2'd3, '1, 1'b1));
        send_word(pack_word(ssm_pkg::OP_EXIT,  2'd3, '1, 1'b1));
        send_word(pack_word(OP_NONE,           2'd3, '1, 1'b1));
        send_word(pack_word(ssm_pkg::OP_CHECK, 2'd3, '1, 1'b1));
        // push client 1 past the default limits
        repeat (10) send_word(pack_word(ssm_pkg::OP_EXIT, 2'd1, '1, 1'b0));
        send_word(pack_word(ssm_pkg::OP_CHECK, 2'd0, '0, 1'b0));
    endtask

    task automatic random_words(input int unsigned quota);
        int unsigned                   n;
        int unsigned                   pick;
        int unsigned                   c;
        ssm_pkg::in_t                  w;
        logic [ssm_pkg::TIME_BITS-1:0] d;
        n = 0;
        while (n < quota)
        begin
            pick = $urandom_range(99);
            c    = $urandom_range(ssm_pkg::LIMIT_CLIENTS - 1);
            if ($urandom_range(7) == 0)
                stall_time[c] = {$urandom, $urandom};
            if (pick < 30)
            begin
                send_word(pack_word(ssm_pkg::OP_EXIT, 2'(c), stall_time[c],
                                    $urandom_range(3) == 0));
                n += 1;
            end
            else if (pick < 55)
            begin
                send_word(pack_word(ssm_pkg::OP_ENTRY, 2'(c), stall_time[c], 1'($urandom)));
                send_word(pack_word(ssm_pkg::OP_EXIT, 2'(c), stall_time[c],
                                    $urandom_range(3) == 0));
                n += 2;
            end
            else if (pick < 70)
            begin
                d = {$urandom, $urandom};
                send_word(pack_word(ssm_pkg::OP_ENTRY, 2'(c), d, 1'($urandom)));
                send_word(pack_word(ssm_pkg::OP_EXIT, 2'(c), d + $urandom_range(1, 1000),
                                    $urandom_range(3) == 0));
                n += 2;
            end
            else if (pick < 85)
            begin
                send_word(pack_word(ssm_pkg::OP_CHECK, 2'($urandom), {$urandom, $urandom},
                                    1'($urandom)));
                n += 1;
            end
            else
            begin
                w = pack_word(2'($urandom), 2'($urandom), {$urandom, $urandom}, 1'($urandom));
                send_word(w);
                if (w.operation != OP_NONE &&
                    !(w.operation != ssm_pkg::OP_CHECK && w.client == 2'd3))
                    n += 1;
            end
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        sb        = new();
        foreach (stall_time[i])
            stall_time[i] = {$urandom, $urandom};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_words();

        for (int p = 0; p < 4; p++)
        begin
            wait_idle();
            load_settings(p);
            if (p == 2)
                load_reg(REG_NONE, '1);
            send_idle_pct = (p == 1) ? 72 : (p == 3) ? 33 : 0;
            stall_pct    <= (p == 2) ? 72 : (p == 3) ? 33 : 0;
            random_words(PHASE_WORDS);
        end

        // repeated stall on client 2 with limits at maximum
        wait_idle();
        send_idle_pct = 0;
        stall_pct    <= 0;
        send_word(pack_word(ssm_pkg::OP_ENTRY, 2'd2, stall_time[2], 1'b0));
        repeat (STALL_EXITS)
            send_word(pack_word(ssm_pkg::OP_EXIT, 2'd2, stall_time[2], 1'($urandom)));
        send_word(pack_word(ssm_pkg::OP_CHECK, 2'd0, '0, 1'b0));
        wait_idle();
        load_reg(ssm_pkg::REG_ERR_LIMIT2, 16'hFFFE);
        send_word(pack_word(ssm_pkg::OP_CHECK, 2'd0, '0, 1'b0));
        wait_idle();

        if (sb.mismatches == 0 && sb.due_reports.size() == 0)
            $display("subsystem_sleep_stall_monitor regression: pass");
        else
            $display("subsystem_sleep_stall_monitor regression: fail");
        $finish;
    end

endmodule
